// ===== hdl/vsns_pkg.sv =====
// Shared types, sizes and helpers for the six-neighbour video smoother.
// Used by every module of the block except vsns_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package vsns_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = 1 + ROW_W + COL_W;
  localparam int RAM_DEPTH  = 2 ** ADDR_W;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int NB_COUNT   = 5;
  localparam int SUM_W      = 11;
  localparam int CNT_W      = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int RECIP_SHIFT = 13;
  localparam logic [11:0] RECIP3 = 12'd2731;
  localparam logic [11:0] RECIP5 = 12'd1639;

  // Neighbour slots: previous frame, up, left, down, right.
  typedef struct packed {
    logic                write;
    logic                emit;
    logic                plane;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [PIX_W-1:0]    pix;
    logic [NB_COUNT-1:0] nb_mask;
    logic                has_next;
    logic                eof;
    logic                eov;
  } job_t;

  function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] s,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W+11:0] p3;
    logic [SUM_W+11:0] p5;
    logic [SUM_W+11:0] q3;
    logic [SUM_W+11:0] q5;
    logic [PIX_W-1:0]  r;
    p3 = (SUM_W + 12)'(s) * (SUM_W + 12)'(RECIP3);
    p5 = (SUM_W + 12)'(s) * (SUM_W + 12)'(RECIP5);
    q3 = p3 >> RECIP_SHIFT;
    q5 = p5 >> RECIP_SHIFT;
    unique case (n)
      3'd1:    r = s[PIX_W-1:0];
      3'd2:    r = s[PIX_W:1];
      3'd3:    r = q3[PIX_W-1:0];
      3'd4:    r = s[PIX_W+1:2];
      3'd5:    r = q5[PIX_W-1:0];
      3'd6:    r = q3[PIX_W:1];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vsns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module vsns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vsns_job_fifo.sv =====
// Short job queue between the front and back parts of the smoother.
// Depends on vsns_pkg for job_t and QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none
module vsns_job_fifo
  import vsns_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vsns_front.sv =====
// Front part: takes input transactions and configuration writes, tracks the
// raster position and frame bookkeeping, and queues one job per useful item.
// Depends on vsns_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsns_front
  import vsns_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 item_accept,
  input  wire logic                 cmd,
  input  wire logic [PIX_W-1:0]     pixel_in,
  output logic                      push,
  output job_t                      push_job
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [1:0]       frames_held;
  logic             store_select;
  logic             flushing;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  logic             flush_cmd;
  logic             at_start;
  logic             last;
  logic             flush_ok;
  logic [CFG_W-1:0] cfg_m1;
  logic [COL_W-1:0] col_last_next;
  logic [ROW_W-1:0] row_last_next;

  assign flush_cmd = (cmd == CMD_FLUSH);
  assign at_start  = (col == '0) && (row == '0);
  assign last      = (col == col_last) && (row == row_last);
  assign flush_ok  = flushing || ((frames_held != 2'd0) && at_start);
  assign push      = item_accept && (flush_cmd ? flush_ok : !flushing);
  assign cfg_m1    = cfg_data - 1'b1;

  always_comb begin
    if (cfg_data < CFG_W'(2)) begin
      col_last_next = COL_W'(1);
    end else if (cfg_data > CFG_W'(MAX_WIDTH)) begin
      col_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last_next = COL_W'(cfg_m1);
    end
    if (cfg_data < CFG_W'(2)) begin
      row_last_next = ROW_W'(1);
    end else if (cfg_data > CFG_W'(MAX_HEIGHT)) begin
      row_last_next = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last_next = ROW_W'(cfg_m1);
    end
  end

  always_comb begin
    push_job.write    = !flush_cmd;
    push_job.emit     = flush_cmd || (frames_held != 2'd0);
    push_job.plane    = store_select;
    push_job.row      = row;
    push_job.col      = col;
    push_job.pix      = pixel_in;
    push_job.nb_mask  = {col != col_last, row != row_last, col != '0, row != '0,
                         frames_held == 2'd2};
    push_job.has_next = !flush_cmd;
    push_job.eof      = last;
    push_job.eov      = flush_cmd && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      frames_held  <= '0;
      store_select <= 1'b0;
      flushing     <= 1'b0;
      col_last     <= COL_W'(MAX_WIDTH - 1);
      row_last     <= ROW_W'(MAX_HEIGHT - 1);
    end else if (cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                               cfg_index == REG_FRAME_HEIGHT)) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        col_last <= col_last_next;
      end else begin
        row_last <= row_last_next;
      end
      col         <= '0;
      row         <= '0;
      frames_held <= '0;
      flushing    <= 1'b0;
    end else if (push) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
      if (flush_cmd) begin
        flushing <= !last;
        if (last) begin
          frames_held <= '0;
        end
      end else if (last) begin
        store_select <= !store_select;
        if (frames_held != 2'd2) begin
          frames_held <= frames_held + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vsns_back.sv =====
// Back part: runs queued jobs against the two frame stores, sums the
// in-bounds neighbours, divides and holds the result for the output channel.
// Depends on vsns_pkg and vsns_ram.
`timescale 1ns / 1ps
`default_nettype none
module vsns_back
  import vsns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire job_t              q_head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [PIX_W-1:0]       m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_LAST,
    ST_DIV
  } state_t;

  state_t           state;
  job_t             job;
  logic [2:0]       step;
  logic [2:0]       rd_slot;
  logic             rd_pend;
  logic [SUM_W-1:0] acc;
  logic [CNT_W-1:0] cnt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              out_load;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign rd_en    = (state == ST_READ);
  assign wr_en    = (state == ST_WRITE) || ((state == ST_LAST) && job.write);
  assign wr_addr  = {!job.plane, job.row, job.col};
  assign out_load = (state == ST_DIV) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (step)
      3'd0:    rd_addr = {!job.plane, job.row, job.col};
      3'd1:    rd_addr = {job.plane, job.row - 1'b1, job.col};
      3'd2:    rd_addr = {job.plane, job.row, job.col - 1'b1};
      3'd3:    rd_addr = {job.plane, job.row + 1'b1, job.col};
      default: rd_addr = {job.plane, job.row, job.col + 1'b1};
    endcase
  end

  vsns_ram #(
    .WIDTH(PIX_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(job.pix),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    rd_slot <= step;
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= (state == ST_READ);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            step  <= '0;
            acc   <= q_head.has_next ? SUM_W'(q_head.pix) : '0;
            cnt   <= CNT_W'(q_head.has_next);
            state <= q_head.emit ? ST_READ : ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          if (rd_pend && job.nb_mask[rd_slot]) begin
            acc <= acc + SUM_W'(rd_data);
            cnt <= cnt + 1'b1;
          end
          step <= step + 1'b1;
          if (step == 3'(NB_COUNT - 1)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (rd_pend && job.nb_mask[rd_slot]) begin
            acc <= acc + SUM_W'(rd_data);
            cnt <= cnt + 1'b1;
          end
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (out_load) begin
            m_tdata <= mean_div(acc, cnt);
            m_tlast <= job.eof;
            m_tuser <= job.eov;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/video_six_neighbour_smoother_core.sv =====
// Six-neighbour spatio-temporal mean filter for an 8-bit luma stream.
// Input channel s_*: tuser is the command (0 pixel, 1 flush tick), tdata the
// pixel in raster order. Output channel m_*: tdata the smoothed pixel, tlast
// marks the last pixel of an output frame, tuser the last pixel of the video.
// Config channel cfg_*: index 0 frame width, index 1 frame height (clamped to
// 2..512); a write to either also empties the block. Write only while idle.
// Output runs one frame behind the input; flush ticks drain the last frame.
// A pixel or flush tick that produces a result passes through the back-end
// states in order: take the job, five registered reads of the frame-store RAM,
// collect the last read and write the pixel if any, then divide; a pixel of the
// first frame only takes the job and writes the pixel. The back end takes a new
// job only once it is through with the last, as the frame store has a single
// read port. A 4-entry job queue decouples input acceptance from the back end,
// and the output register holds a result while the receiver stalls; once the
// queue fills, s_tready drops. Ignored items are accepted without a job.
// Reset empties the block and selects a 512 by 512 frame; frame-store
// contents are not cleared and are never used before being written.
// Depends on vsns_pkg, vsns_front, vsns_job_fifo, vsns_back, vsns_ram.
`timescale 1ns / 1ps
`default_nettype none
module video_six_neighbour_smoother_core
  import vsns_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
  input  wire logic                 s_tuser,   // [0] cmd
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [PIX_W-1:0]          m_tdata,   // [7:0] smoothed
  output logic                      m_tlast,
  output logic                      m_tuser,   // [0] end_of_video
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t q_head;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;

  vsns_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_accept(s_tvalid && s_tready),
    .cmd        (s_tuser),
    .pixel_in   (s_tdata),
    .push       (push),
    .push_job   (push_job)
  );

  vsns_job_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  vsns_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for video_six_neighbour_smoother_core: a scoreboard class
// predicts each smoothed pixel from the accepted pixels, flush ticks and sizes.
// Depends on vsns_pkg and the smoother RTL.
module testbench;
  import vsns_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam int PLANE_PIXELS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEMS_PER_MODE = 100;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic             end_of_frame;
    logic             end_of_video;
  } smoothed_pixel_t;

  class smoothing_scoreboard;
    bit [PIX_W-1:0] plane [2][PLANE_PIXELS];
    bit [CFG_W-1:0] width_reg;
    bit [CFG_W-1:0] height_reg;
    int unsigned    col;
    int unsigned    row;
    int unsigned    held;
    bit             sel;
    bit             draining;
    smoothed_pixel_t expected_pixels[$];
    int             errors;

    function new();
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      sel        = 1'b0;
      errors     = 0;
      empty_block();
    endfunction

    function int unsigned clamp(bit [CFG_W-1:0] v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void empty_block();
      col      = 0;
      row      = 0;
      held     = 0;
      draining = 1'b0;
    endfunction

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else if (idx == REG_FRAME_HEIGHT) height_reg = val;
      else return;
      empty_block();
    endfunction

    function bit [PIX_W-1:0] neighbour_mean(int unsigned r, int unsigned c,
                                            int unsigned w, int unsigned h,
                                            bit has_prev, bit has_next,
                                            bit [PIX_W-1:0] next_val);
      int unsigned sum;
      int unsigned cnt;
      int unsigned base;
      base = r * MAX_WIDTH + c;
      sum  = 0;
      cnt  = 0;
      if (has_prev) begin sum += plane[sel ^ 1'b1][base]; cnt++; end
      if (has_next) begin sum += next_val; cnt++; end
      if (r > 0) begin sum += plane[sel][base - MAX_WIDTH]; cnt++; end
      if (c > 0) begin sum += plane[sel][base - 1]; cnt++; end
      if (r + 1 < h) begin sum += plane[sel][base + MAX_WIDTH]; cnt++; end
      if (c + 1 < w) begin sum += plane[sel][base + 1]; cnt++; end
      if (cnt == 0) return '0;
      return PIX_W'(sum / cnt);
    endfunction

    function bit advance(int unsigned w, int unsigned h);
      bit last;
      last = (col + 1 >= w) && (row + 1 >= h);
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
      return last;
    endfunction

    function void note_input(bit cmd, bit [PIX_W-1:0] pix);
      int unsigned     w;
      int unsigned     h;
      smoothed_pixel_t e;
      bit              last;
      bit              produce;
      w = clamp(width_reg, MAX_WIDTH);
      h = clamp(height_reg, MAX_HEIGHT);
      if (col >= w || row >= h) begin
        col = 0;
        row = 0;
      end
      if (cmd == CMD_FLUSH) begin
        if (!draining) begin
          if (held == 0 || row != 0 || col != 0) return;
          draining = 1'b1;
        end
        e.smoothed     = neighbour_mean(row, col, w, h, held >= 2, 1'b0, '0);
        last           = advance(w, h);
        e.end_of_frame = last;
        e.end_of_video = last;
        expected_pixels.insert(expected_pixels.size(), e);
        if (last) empty_block();
        return;
      end
      if (draining) return;
      produce = (held >= 1);
      if (produce) e.smoothed = neighbour_mean(row, col, w, h, held >= 2, 1'b1, pix);
      plane[sel ^ 1'b1][row * MAX_WIDTH + col] = pix;
      last = advance(w, h);
      if (produce) begin
        e.end_of_frame = last;
        e.end_of_video = 1'b0;
        expected_pixels.insert(expected_pixels.size(), e);
      end
      if (last) begin
        sel = ~sel;
        if (held < 2) held++;
      end
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_output(bit [PIX_W-1:0] data, bit eof, bit eov);
      smoothed_pixel_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %0d tlast %0b tuser %0b", data, eof, eov));
        return;
      end
      e = expected_pixels.pop_front();
      if (data != e.smoothed)
        report($sformatf("smoothed %0d, want %0d", data, e.smoothed));
      if (eof != e.end_of_frame)
        report($sformatf("tlast %0b, want %0b", eof, e.end_of_frame));
      if (eov != e.end_of_video)
        report($sformatf("tuser %0b, want %0b", eov, e.end_of_video));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [PIX_W-1:0]     s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [PIX_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int                   send_idle = 0;
  int                   recv_stall = 0;
  bit                   hold_armed = 1'b0;
  bit                   hold_done = 1'b0;
  int unsigned          cycles = 0;
  smoothing_scoreboard  sb;

  video_six_neighbour_smoother_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast, m_tuser);
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel(input bit bright);
    if (bright && $urandom_range(7) != 0) return '1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit poke_unused);
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    if (poke_unused) write_register(REG_UNUSED, CFG_W'($urandom_range(1023)));
    cfg_valid <= 1'b0;
  endtask

  // Whole frames, then a full flush; a noisy video adds stray flush ticks
  // mid-frame, stray pixels mid-flush, or drops the flush altogether.
  task automatic send_video(input int unsigned w, input int unsigned h, input int frames,
                            input bit noisy, input bit bright, output int unsigned sent);
    sent = 0;
    for (int f = 0; f < frames; f++) begin
      for (int unsigned p = 0; p < w * h; p++) begin
        if (noisy && p != 0 && $urandom_range(15) == 0)
          send_item(CMD_FLUSH, random_pixel(bright));
        send_item(CMD_PIXEL, random_pixel(bright));
        sent++;
      end
    end
    if (noisy && $urandom_range(2) == 0) return;
    for (int unsigned p = 0; p < w * h; p++) begin
      if (noisy && p != 0 && $urandom_range(15) == 0)
        send_item(CMD_PIXEL, random_pixel(bright));
      send_item(CMD_FLUSH, random_pixel(bright));
      sent++;
    end
  endtask

  initial begin
    int unsigned    sent;
    int unsigned    mode_items;
    int unsigned    w;
    int unsigned    h;
    logic [CFG_W-1:0] wr;
    logic [CFG_W-1:0] hr;
    logic [8:0]     directed[$];
    sb = new();
    // {cmd, pixel} on a 2 by 2 frame
    directed = '{
      {CMD_FLUSH, 8'h00},
      {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF},
      {CMD_PIXEL, 8'hFF}, {CMD_FLUSH, 8'h00}, {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'hFF},
      {CMD_PIXEL, 8'h00},
      {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'h00},
      {CMD_FLUSH, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_FLUSH, 8'h00}, {CMD_FLUSH, 8'h00},
      {CMD_FLUSH, 8'h00},
      {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'hFF},
      {CMD_FLUSH, 8'h00}, {CMD_FLUSH, 8'h00}, {CMD_FLUSH, 8'h00}, {CMD_FLUSH, 8'h00}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    configure(10'd0, 10'd1, 1'b1);
    foreach (directed[i]) send_item(directed[i][8], directed[i][7:0]);
    wait_idle();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 66; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      if (mode == 0) hold_armed = 1'b1;
      mode_items = 0;
      while (mode_items < ITEMS_PER_MODE) begin
        if (mode_items == 0 || $urandom_range(1) == 0) begin
          wr = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1))
                                        : CFG_W'($urandom_range(2, 9));
          hr = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1))
                                        : CFG_W'($urandom_range(2, 6));
          wait_idle();
          configure(wr, hr, $urandom_range(7) == 0);
          w = sb.clamp(wr, MAX_WIDTH);
          h = sb.clamp(hr, MAX_HEIGHT);
        end
        send_video(w, h, $urandom_range(1, 3), $urandom_range(4) == 0,
                   $urandom_range(5) == 0, sent);
        mode_items += sent;
      end
      wait_idle();
    end

    wait_idle();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
